// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define FBPA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fbpa check failed");

// next-cycle implication, disabled while reset is low
`define FBPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fbpa check failed");

`endif

// ===== rtl/fbpa_pkg.sv =====
package fbpa_pkg;

  // field widths
  localparam int unsigned SIZE_W  = 17;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned OFF_W   = 22;

  // built pool capacity
  localparam int unsigned NUM_BLOCKS_DEF = 64;

  // register reset values
  localparam logic [SIZE_W-1:0]  SIZE_RST  = SIZE_W'(64);
  localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(64);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

  // request kinds
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [DATA_W-1:0] free_offset;
    logic              is_null;
  } req_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] block_index;
    logic [OFF_W-1:0] block_offset;
  } rsp_t;

endpackage

// ===== rtl/fixed_block_pool_allocator.sv =====
// First-fit allocator over a pool of fixed-size blocks, one free flag per block.
// A request is taken when start is high and busy is low; its single result is
// shown on rsp_o for one cycle with done_o high, and cannot be held off, so the
// receiver must capture it in that cycle. An allocate scans the flag memory one
// block per cycle up to the effective block count (block_count capped at
// NUM_BLOCKS) and grants the first free block, else fails. A free runs a
// restoring divider of the offset by block_size, one quotient bit per cycle; a
// null free skips the divider. After reset the flag memory is swept to all free,
// one block per cycle, with busy high; configuration writes are taken during the
// sweep. Configuration is to be written only when idle; the block does not
// enforce it.
module fixed_block_pool_allocator #(
  parameter int unsigned NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  fbpa_pkg::req_t                       req_i,
  output logic                                 done_o,
  output fbpa_pkg::rsp_t                       rsp_o,
  input  logic                                 cfg_we_i,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [fbpa_pkg::SIZE_W-1:0]          cfg_wdata_i
);
  import fbpa_pkg::*;

  localparam int unsigned IW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int unsigned CW  = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned DCW = $clog2(DATA_W);
  localparam logic [IW-1:0]  LAST_BLK = IW'(NUM_BLOCKS - 1);
  localparam logic [DCW-1:0] LAST_BIT = DCW'(DATA_W - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_FREE_CHK
  } state_e;

  state_e             state_q;
  logic [SIZE_W-1:0]  size_q;
  logic [COUNT_W-1:0] count_q;
  logic [IW-1:0]      clr_q;
  logic [IW-1:0]      scan_idx_q;
  logic [IW-1:0]      chk_idx_q;
  logic               chk_vld_q;
  logic               rd_data_q;
  logic [SIZE_W-1:0]  rem_q;
  logic [DATA_W-1:0]  quot_q;
  logic [DCW-1:0]     div_cnt_q;
  logic               null_q;
  logic               done_q;
  rsp_t               rsp_q;

  // free flag memory
  logic               flags_mem [NUM_BLOCKS];

  logic [SIZE_W-1:0]  eff_size;
  logic [CW-1:0]      eff_count;
  logic               scan_hit;
  logic               scan_last;
  logic [SIZE_W:0]    rem_shift;
  logic               rem_ge;
  logic [SIZE_W:0]    rem_diff;
  logic               free_in_range;
  logic [IW+SIZE_W-1:0] grant_prod;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic               mem_wdata;

  // effective register values
  assign eff_size  = (size_q == '0) ? SIZE_W'(1) : size_q;
  assign eff_count = (32'(count_q) > 32'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : CW'(count_q);

  // scan compare
  assign scan_hit  = chk_vld_q && rd_data_q;
  assign scan_last = (CW'(chk_idx_q) == eff_count - CW'(1));

  // one restoring division step
  assign rem_shift = {rem_q, quot_q[DATA_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, eff_size});
  assign rem_diff  = rem_shift - {1'b0, eff_size};

  assign free_in_range = !null_q && (quot_q < DATA_W'(eff_count));

  // byte offset of the granted block
  assign grant_prod = {{SIZE_W{1'b0}}, chk_idx_q} * {{IW{1'b0}}, eff_size};

  // single write port of the flag memory
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = 1'b1;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_SCAN: begin
        mem_we    = scan_hit && (eff_count != '0);
        mem_waddr = chk_idx_q;
        mem_wdata = 1'b0;
      end
      ST_FREE_CHK: begin
        mem_we    = free_in_range;
        mem_waddr = quot_q[IW-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      flags_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= flags_mem[scan_idx_q];
  end

  // sequencer, configuration and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      size_q     <= SIZE_RST;
      count_q    <= COUNT_RST;
      clr_q      <= '0;
      scan_idx_q <= '0;
      chk_idx_q  <= '0;
      chk_vld_q  <= 1'b0;
      rem_q      <= '0;
      quot_q     <= '0;
      div_cnt_q  <= '0;
      null_q     <= 1'b0;
      done_q     <= 1'b0;
      rsp_q      <= '0;
    end else begin
      done_q <= 1'b0;

      // configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BLOCK_SIZE:  size_q  <= cfg_wdata_i;
          CFG_BLOCK_COUNT: count_q <= cfg_wdata_i[COUNT_W-1:0];
          default: ;
        endcase
      end

      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + IW'(1);
          if (clr_q == LAST_BLK) begin
            state_q <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (start) begin
            quot_q     <= req_i.free_offset;
            rem_q      <= '0;
            div_cnt_q  <= '0;
            null_q     <= req_i.is_null;
            scan_idx_q <= '0;
            chk_vld_q  <= 1'b0;
            if (req_i.mode == MODE_FREE) begin
              state_q <= req_i.is_null ? ST_FREE_CHK : ST_DIV;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          chk_idx_q <= scan_idx_q;
          chk_vld_q <= 1'b1;
          if (scan_idx_q != LAST_BLK) begin
            scan_idx_q <= scan_idx_q + IW'(1);
          end
          if (eff_count == '0) begin
            rsp_q   <= '0;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else if (scan_hit) begin
            rsp_q.ok           <= 1'b1;
            rsp_q.block_index  <= IDX_W'(chk_idx_q);
            rsp_q.block_offset <= OFF_W'(grant_prod);
            done_q             <= 1'b1;
            state_q            <= ST_IDLE;
          end else if (chk_vld_q && scan_last) begin
            rsp_q   <= '0;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end

        ST_DIV: begin
          rem_q     <= rem_ge ? rem_diff[SIZE_W-1:0] : rem_shift[SIZE_W-1:0];
          quot_q    <= {quot_q[DATA_W-2:0], rem_ge};
          div_cnt_q <= div_cnt_q + DCW'(1);
          if (div_cnt_q == LAST_BIT) begin
            state_q <= ST_FREE_CHK;
          end
        end

        ST_FREE_CHK: begin
          rsp_q.ok           <= free_in_range;
          rsp_q.block_index  <= free_in_range ? quot_q[IDX_W-1:0] : '0;
          rsp_q.block_offset <= '0;
          done_q             <= 1'b1;
          state_q            <= ST_IDLE;
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== rtl/fbpa_checker.sv =====
`include "assert_macros.svh"

module fbpa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start,
  input logic                           busy,
  input logic                           done_o,
  input fbpa_pkg::rsp_t                 rsp_o
);
  import fbpa_pkg::*;

  // a start transfer always leads into a busy state
  `FBPA_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)

  // a result is shown only once the work has ended
  `FBPA_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_o, !busy)

  // results never come in back-to-back cycles
  `FBPA_ASSERT_NOW(a_done_single, clk_i, rst_ni, done_o, !$past(done_o))

  // a refused request reports a cleared index and offset
  `FBPA_ASSERT_NOW(a_fail_zero, clk_i, rst_ni, done_o && !rsp_o.ok,
                   rsp_o.block_index == '0 && rsp_o.block_offset == '0)

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fbpa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned N_DIR       = 26;
  localparam int unsigned N_PHASE     = 9;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned MAX_GAP     = 40;
  localparam int unsigned SETTLE      = 80;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [SIZE_W-1:0]    reg_val;
    req_t                 req;
    logic                 typed;
    rsp_t                 rsp;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req;
  logic done;
  rsp_t rsp;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [SIZE_W-1:0] cfg_wdata_i;

  // own copy of the pool state and registers
  logic [SIZE_W-1:0]  pool_size;
  logic [COUNT_W-1:0] pool_count;
  logic               blk_free [NUM_BLOCKS_DEF];

  rsp_t        awaited_rsp_q [$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned sender_idle_pct;
  int unsigned alloc_pct;

  // directed stimulus: typed expectation where it is obvious, else predicted
  dir_row_t dir_tab [N_DIR] = '{
    '{ROW_REQ, CFG_BLOCK_SIZE, 17'd0, '{MODE_ALLOC, 32'h0, 1'b0}, 1'b1, '{1'b1, 6'd0, 22'd0}},
    '{ROW_REQ, CFG_BLOCK_SIZE, 17'd0, '{MODE_ALLOC, 32'hFFFF_FFFF, 1'b1}, 1'b1,
      '{1'b1, 6'd1, 22'd64}},
    '{ROW_REQ, CFG_BLOCK_SIZE, 17'd0, '{MODE_FREE, 32'h0, 1'b0}, 1'b1, '{1'b1, 6'd0, 22'd0}},
    // double free stays legal
    '{ROW_REQ, CFG_BLOCK_SIZE, 17'd0, '{MODE_FREE, 32'h0, 1'b0}, 1'b1, '{1'b1, 6'd0, 22'd0}},
    // null handle
    '{ROW_REQ, CFG_BLOCK_SIZE, 17'd0, '{MODE_FREE, 32'd64, 1'b1}, 1'b1, '{1'b0, 6'd0, 22'd0}},
    '{ROW_REQ, CFG_BLOCK_SIZE, 17'd0, '{MODE_FREE, 32'hFFFF_FFFF, 1'b0}, 1'b1,
      '{1'b0, 6'd0, 22'd0}},
    '{ROW_REQ, CFG_BLOCK_SIZE, 17'd0, '{MODE_FREE, 32'd4095, 1'b0}, 1'b1, '{1'b1, 6'd63, 22'd0}},
    '{ROW_REQ, CFG_BLOCK_SIZE, 17'd0, '{MODE_FREE, 32'd4096, 1'b0}, 1'b1, '{1'b0, 6'd0, 22'd0}},
    '{ROW_REQ, CFG_BLOCK_SIZE, 17'd0, '{MODE_ALLOC, 32'h0, 1'b0}, 1'b1, '{1'b1, 6'd0, 22'd0}},
    // zero size behaves as one byte, two blocks only
    '{ROW_CFG, CFG_BLOCK_SIZE, 17'd0, '0, 1'b0, '0},
    '{ROW_CFG, CFG_BLOCK_COUNT, 17'd2, '0, 1'b0, '0},
    '{ROW_REQ, CFG_BLOCK_SIZE, 17'd0, '{MODE_ALLOC, 32'h0, 1'b0}, 1'b1, '{1'b0, 6'd0, 22'd0}},
    '{ROW_REQ, CFG_BLOCK_SIZE, 17'd0, '{MODE_FREE, 32'd1, 1'b0}, 1'b1, '{1'b1, 6'd1, 22'd0}},
    '{ROW_REQ, CFG_BLOCK_SIZE, 17'd0, '{MODE_ALLOC, 32'd5, 1'b0}, 1'b1, '{1'b1, 6'd1, 22'd1}},
    '{ROW_REQ, CFG_BLOCK_SIZE, 17'd0, '{MODE_FREE, 32'd2, 1'b0}, 1'b1, '{1'b0, 6'd0, 22'd0}},
    // widest size, count beyond capacity
    '{ROW_CFG, CFG_BLOCK_SIZE, 17'h1FFFF, '0, 1'b0, '0},
    '{ROW_CFG, CFG_BLOCK_COUNT, 17'h1FFFF, '0, 1'b0, '0},
    '{ROW_REQ, CFG_BLOCK_SIZE, 17'd0, '{MODE_ALLOC, 32'h0, 1'b0}, 1'b0, '0},
    '{ROW_REQ, CFG_BLOCK_SIZE, 17'd0, '{MODE_FREE, 32'd393212, 1'b0}, 1'b0, '0},
    '{ROW_REQ, CFG_BLOCK_SIZE, 17'd0, '{MODE_FREE, 32'hFFFF_FFFF, 1'b0}, 1'b1,
      '{1'b0, 6'd0, 22'd0}},
    // no blocks at all
    '{ROW_CFG, CFG_BLOCK_COUNT, 17'd0, '0, 1'b0, '0},
    '{ROW_REQ, CFG_BLOCK_SIZE, 17'd0, '{MODE_ALLOC, 32'h0, 1'b0}, 1'b1, '{1'b0, 6'd0, 22'd0}},
    '{ROW_REQ, CFG_BLOCK_SIZE, 17'd0, '{MODE_FREE, 32'h0, 1'b0}, 1'b1, '{1'b0, 6'd0, 22'd0}},
    '{ROW_CFG, CFG_BLOCK_SIZE, 17'd64, '0, 1'b0, '0},
    '{ROW_CFG, CFG_BLOCK_COUNT, 17'd64, '0, 1'b0, '0},
    '{ROW_REQ, CFG_BLOCK_SIZE, 17'd0, '{MODE_FREE, 32'h0, 1'b1}, 1'b1, '{1'b0, 6'd0, 22'd0}}
  };

  // register settings and sender idling per random phase
  int unsigned phase_size [N_PHASE] = '{64, 1, 65536, 131071, 0, 3, 0, 1000, 777};
  int unsigned phase_count [N_PHASE] = '{64, 64, 64, 127, 1, 5, 0, 0, 65};
  int unsigned phase_idle [N_PHASE] = '{0, 76, 0, 17, 76, 17, 76, 0, 17};
  bit          phase_rand [N_PHASE] = '{0, 0, 0, 0, 0, 0, 1, 0, 0};

  fixed_block_pool_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .done_o     (done),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // effective block count and block size
  function automatic int unsigned live_blocks();
    return (pool_count > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(pool_count);
  endfunction

  function automatic longint unsigned block_bytes();
    return (pool_size == '0) ? 1 : longint'(pool_size);
  endfunction

  // first-fit grant or release, updates the flag copy
  function automatic rsp_t pool_response(req_t r);
    rsp_t              res;
    int unsigned       cnt;
    longint unsigned   sz;
    longint unsigned   idx;
    bit                found;
    res   = '0;
    cnt   = live_blocks();
    sz    = block_bytes();
    found = 1'b0;
    if (r.mode == MODE_ALLOC) begin
      for (int i = 0; i < cnt && !found; i++) begin
        if (blk_free[i]) begin
          blk_free[i]      = 1'b0;
          found            = 1'b1;
          res.ok           = 1'b1;
          res.block_index  = IDX_W'(i);
          res.block_offset = OFF_W'(longint'(i) * sz);
        end
      end
    end else if (!r.is_null) begin
      idx = longint'(r.free_offset) / sz;
      if (idx < cnt) begin
        blk_free[idx]   = 1'b1;
        res.ok          = 1'b1;
        res.block_index = IDX_W'(idx);
      end
    end
    return res;
  endfunction

  // random request; a free mostly names a block actually held
  function automatic req_t make_request();
    req_t            r;
    int unsigned     held_q [$];
    int unsigned     cnt;
    int unsigned     pick;
    int unsigned     kind;
    longint unsigned sz;
    cnt           = live_blocks();
    sz            = block_bytes();
    r.mode        = ($urandom_range(99) < alloc_pct) ? MODE_ALLOC : MODE_FREE;
    r.free_offset = $urandom();
    r.is_null     = $urandom_range(1);
    if (r.mode == MODE_FREE) begin
      for (int unsigned i = 0; i < cnt; i++) begin
        if (!blk_free[i]) held_q = {held_q, i};
      end
      kind      = $urandom_range(99);
      r.is_null = 1'b0;
      if (kind < 10) begin
        r.is_null = 1'b1;
      end else if (kind >= 20 && cnt != 0) begin
        if (kind < 25) pick = cnt;
        else if (kind < 80 && held_q.size() != 0) pick = held_q[$urandom_range(held_q.size() - 1)];
        else pick = $urandom_range(cnt - 1);
        r.free_offset = 32'(longint'(pick) * sz + $urandom_range(32'(sz - 1)));
      end
    end
    return r;
  endfunction

  // one request transfer, optionally after an idle gap
  task automatic issue_request(req_t r, logic typed, rsp_t typed_rsp);
    rsp_t predicted;
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy);
    predicted = pool_response(r);
    awaited_rsp_q = {awaited_rsp_q, (typed ? typed_rsp : predicted)};
  endtask

  // hold off until every response is back and the block is idle
  task automatic drain_pool();
    start <= 1'b0;
    while (awaited_rsp_q.size() != 0 || busy) @(posedge clk_i);
  endtask

  // register write, then a quiet wait with the write enable low
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BLOCK_SIZE) pool_size = val;
    else pool_count = val[COUNT_W-1:0];
    @(posedge clk_i);
  endtask

  // response checking
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done) begin
      if (awaited_rsp_q.size() == 0) begin
        $error("unexpected response: ok %0d index %0d offset %0d",
               rsp.ok, rsp.block_index, rsp.block_offset);
        err_cnt++;
      end else begin
        want = awaited_rsp_q.pop_front();
        if (rsp.ok !== want.ok) begin
          $error("ok: expected %0d, actual %0d", want.ok, rsp.ok);
          err_cnt++;
        end
        if (rsp.block_index !== want.block_index) begin
          $error("block_index: expected %0d, actual %0d", want.block_index, rsp.block_index);
          err_cnt++;
        end
        if (rsp.block_offset !== want.block_offset) begin
          $error("block_offset: expected %0d, actual %0d", want.block_offset, rsp.block_offset);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    dir_row_t row;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    start           = 1'b0;
    req             = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_BLOCK_SIZE;
    cfg_wdata_i     = '0;
    err_cnt         = 0;
    cycle_cnt       = 0;
    sender_idle_pct = 0;
    alloc_pct       = 50;
    pool_size       = SIZE_RST;
    pool_count      = COUNT_RST;
    for (int i = 0; i < NUM_BLOCKS_DEF; i++) blk_free[i] = 1'b1;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    for (int k = 0; k < N_DIR; k++) begin
      row = dir_tab[k];
      if (row.kind == ROW_CFG) begin
        drain_pool();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        issue_request(row.req, row.typed, row.rsp);
      end
    end

    // random part, fill and release bursts per phase
    for (int p = 0; p < N_PHASE; p++) begin
      drain_pool();
      if (phase_rand[p]) begin
        write_reg(CFG_BLOCK_SIZE, SIZE_W'($urandom()));
        write_reg(CFG_BLOCK_COUNT, SIZE_W'($urandom_range(127)));
      end else begin
        write_reg(CFG_BLOCK_SIZE, SIZE_W'(phase_size[p]));
        write_reg(CFG_BLOCK_COUNT, SIZE_W'(phase_count[p]));
      end
      sender_idle_pct = phase_idle[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) alloc_pct = $urandom_range(20, 85);
        if ($urandom_range(99) == 0) drain_pool();
        issue_request(make_request(), 1'b0, '0);
      end
    end

    drain_pool();
    repeat (SETTLE) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
